FILE: src/ue0_pkg.sv
// Shared types, codes and the descriptor ROM of the endpoint-0 request responder.
// No dependencies; imported by ue0_decode and usb_ep0_request_responder.
package ue0_pkg;

  localparam int PACKET_BYTES = 8;
  localparam int ROM_SIZE     = 76;

  // Endpoint events.
  localparam logic [2:0] OP_SETUP     = 3'd0;
  localparam logic [2:0] OP_IN_DONE   = 3'd1;
  localparam logic [2:0] OP_OUT_DONE  = 3'd2;
  localparam logic [2:0] OP_BUS_RESET = 3'd3;
  localparam logic [2:0] OP_OTHER     = 3'd4;

  // Result actions.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_DATA  = 3'd1;
  localparam logic [2:0] ACT_ZLP   = 3'd2;
  localparam logic [2:0] ACT_STALL = 3'd3;
  localparam logic [2:0] ACT_DFU   = 3'd4;
  localparam logic [2:0] ACT_DONE  = 3'd5;

  // Standard request codes.
  localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'h0A;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'h0B;

  // Vendor enter-DFU request.
  localparam logic [7:0]  RT_DFU       = 8'h21;
  localparam logic [7:0]  REQ_DFU      = 8'h00;
  localparam logic [15:0] VAL_DFU      = 16'h000A;
  localparam logic [7:0]  RT_TYPE_MASK = 8'h60;

  // Descriptor types and string indexes.
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;
  localparam logic [7:0] STR_LANG    = 8'd0;
  localparam logic [7:0] STR_MFR     = 8'd1;
  localparam logic [7:0] STR_PRODUCT = 8'd2;

  // ROM layout.
  localparam logic [6:0] BASE_DEVICE  = 7'd0;
  localparam logic [6:0] BASE_CONFIG  = 7'd18;
  localparam logic [6:0] BASE_LANG    = 7'd36;
  localparam logic [6:0] BASE_MFR     = 7'd40;
  localparam logic [6:0] BASE_PRODUCT = 7'd58;
  localparam logic [4:0] LEN_FULL     = 5'd18;
  localparam logic [4:0] LEN_LANG     = 5'd4;

  localparam logic [7:0] ADDR_NONE = 8'hFF;

  localparam logic [7:0] DESC_ROM [ROM_SIZE] = '{
    // device descriptor
    8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08,
    8'hBA, 8'h0D, 8'h00, 8'h10, 8'hAD, 8'hDE, 8'h01, 8'h02, 8'h00, 8'h01,
    // configuration and interface
    8'h09, 8'h02, 8'h12, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hFA,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
    // language list
    8'h04, 8'h03, 8'h09, 8'h04,
    // manufacturer string
    8'h12, 8'h03, 8'h44, 8'h00, 8'h69, 8'h00, 8'h67, 8'h00, 8'h69, 8'h00,
    8'h53, 8'h00, 8'h61, 8'h00, 8'h66, 8'h00, 8'h65, 8'h00,
    // product string
    8'h12, 8'h03, 8'h4D, 8'h00, 8'h42, 8'h00, 8'h4F, 8'h00, 8'h58, 8'h00,
    8'h2D, 8'h00, 8'h53, 8'h00, 8'h41, 8'h00, 8'h46, 8'h00
  };

  // Addresses past the end of the ROM read as zero.
  function automatic logic [7:0] rom_byte(input logic [7:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < 8'(ROM_SIZE)) begin
      b = DESC_ROM[idx[6:0]];
    end
    return b;
  endfunction

  typedef struct packed {
    logic [7:0] staged_addr;
    logic [7:0] cur_addr;
    logic [5:0] desc_off;
    logic [4:0] remaining;
    logic [1:0] stall;
    logic [1:0] toggle;
    logic       enable;
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  count;
    logic [63:0] bytes;
  } reply_t;

endpackage

FILE: src/ue0_decode.sv
// Combinational decode of one endpoint-0 event against the current state.
// Depends on ue0_pkg for codes, the descriptor ROM and the state/reply types.
module ue0_decode (
  input  logic [2:0]      op,
  input  logic [7:0]      request_type,
  input  logic [7:0]      request_code,
  input  logic [15:0]     request_value,
  input  logic [15:0]     request_length,
  input  ue0_pkg::state_t st_cur,
  output ue0_pkg::state_t st_nxt,
  output ue0_pkg::reply_t reply
);
  import ue0_pkg::*;

  logic [7:0]  vl;
  logic [7:0]  vh;
  logic        desc_hit;
  logic [6:0]  desc_base;
  logic [4:0]  desc_len;
  logic [4:0]  total;
  logic [7:0]  chunk_addr;
  logic [4:0]  avail;
  logic [3:0]  chunk;
  logic [7:0]  end_addr;
  logic [63:0] chunk_bytes;

  assign vl = request_value[7:0];
  assign vh = request_value[15:8];

  always_comb begin
    desc_hit  = 1'b0;
    desc_base = BASE_DEVICE;
    desc_len  = LEN_FULL;
    if (vh == DESC_DEVICE) begin
      desc_hit = 1'b1;
    end else if (vh == DESC_CONFIG) begin
      desc_hit  = 1'b1;
      desc_base = BASE_CONFIG;
    end else if (vh == DESC_STRING) begin
      if (vl == STR_LANG) begin
        desc_hit  = 1'b1;
        desc_base = BASE_LANG;
        desc_len  = LEN_LANG;
      end else if (vl == STR_MFR) begin
        desc_hit  = 1'b1;
        desc_base = BASE_MFR;
      end else if (vl == STR_PRODUCT) begin
        desc_hit  = 1'b1;
        desc_base = BASE_PRODUCT;
      end
    end
  end

  assign total = (request_length < {11'd0, desc_len}) ? request_length[4:0] : desc_len;

  // One chunk path serves both the first packet and its continuations.
  always_comb begin
    if (op == OP_SETUP) begin
      chunk_addr = {1'b0, desc_base};
      avail      = total;
    end else begin
      chunk_addr = {1'b0, st_cur.desc_off, 1'b0};
      avail      = st_cur.remaining;
    end
    chunk = (avail > 5'(PACKET_BYTES)) ? 4'(PACKET_BYTES) : avail[3:0];
    end_addr = chunk_addr + {4'd0, chunk};
    chunk_bytes = '0;
    for (int i = 0; i < PACKET_BYTES; i++) begin
      if (4'(i) < chunk) begin
        chunk_bytes[i*8 +: 8] = rom_byte(chunk_addr + 8'(i));
      end
    end
  end

  always_comb begin
    st_nxt       = st_cur;
    reply.action = ACT_NONE;
    reply.count  = 4'd0;
    reply.bytes  = 64'd0;
    case (op)
      OP_SETUP: begin
        st_nxt.stall  = 2'b00;
        st_nxt.toggle = 2'b11;
        if (request_type == RT_DFU && request_code == REQ_DFU && request_value == VAL_DFU) begin
          reply.action = ACT_DFU;
        end else if ((request_type & RT_TYPE_MASK) == 8'h00) begin
          case (request_code)
            REQ_GET_STATUS: begin
              reply.action     = ACT_DATA;
              reply.count      = 4'd2;
              st_nxt.remaining = 5'd0;
            end
            REQ_SET_ADDRESS: begin
              st_nxt.staged_addr = vl;
              reply.action       = ACT_ZLP;
            end
            REQ_GET_DESCRIPTOR: begin
              if (!desc_hit) begin
                st_nxt.stall = 2'b11;
                reply.action = ACT_STALL;
              end else if (total == 5'd0) begin
                reply.action     = ACT_ZLP;
                st_nxt.desc_off  = desc_base[6:1];
                st_nxt.remaining = 5'd0;
              end else begin
                reply.action     = ACT_DATA;
                reply.count      = chunk;
                reply.bytes      = chunk_bytes;
                st_nxt.desc_off  = end_addr[6:1];
                st_nxt.remaining = avail - {1'b0, chunk};
              end
            end
            REQ_GET_CONFIG: begin
              reply.action     = ACT_DATA;
              reply.count      = 4'd1;
              reply.bytes      = 64'd1;
              st_nxt.remaining = 5'd0;
            end
            REQ_GET_INTERFACE: begin
              reply.action     = ACT_DATA;
              reply.count      = 4'd1;
              st_nxt.remaining = 5'd0;
            end
            REQ_SET_CONFIG, REQ_SET_INTERFACE: begin
              reply.action = ACT_ZLP;
            end
            default: begin
              st_nxt.stall = 2'b11;
              reply.action = ACT_STALL;
            end
          endcase
        end else begin
          st_nxt.stall = 2'b11;
          reply.action = ACT_STALL;
        end
      end
      OP_IN_DONE: begin
        if (st_cur.staged_addr != ADDR_NONE) begin
          st_nxt.cur_addr    = st_cur.staged_addr;
          st_nxt.staged_addr = ADDR_NONE;
        end
        if (st_cur.remaining != 5'd0) begin
          reply.action     = ACT_DATA;
          reply.count      = chunk;
          reply.bytes      = chunk_bytes;
          st_nxt.desc_off  = end_addr[6:1];
          st_nxt.remaining = avail - {1'b0, chunk};
        end else begin
          st_nxt.stall  = 2'b00;
          st_nxt.toggle = 2'b00;
          reply.action  = ACT_DONE;
        end
      end
      OP_BUS_RESET: begin
        st_nxt.stall       = 2'b00;
        st_nxt.toggle      = 2'b00;
        st_nxt.cur_addr    = 8'd0;
        st_nxt.enable      = 1'b1;
        st_nxt.staged_addr = ADDR_NONE;
        st_nxt.remaining   = 5'd0;
      end
      OP_OUT_DONE, OP_OTHER: begin
        reply.action = ACT_NONE;
      end
      default: begin
        reply.action = ACT_NONE;
      end
    endcase
  end

endmodule

FILE: src/usb_ep0_request_responder.sv
// Top level of the endpoint-0 standard request responder: input register, state, result register.
// Depends on ue0_pkg and ue0_decode.
//
// Usage: each endpoint-0 event enters on the in_ stream (op in in_tuser, the setup packet
// fields in in_tdata) and yields exactly one result item on the out_ stream (action in
// out_tuser, packet bytes, address and endpoint flags in out_tdata).
// Timing: an accepted item is held in the input register, decoded against the endpoint
// state and loaded into the output register once that register is free, which raises
// out_tvalid, and the result is taken while out_tready is high.
// Throughput: one item per cycle while out_tready stays high. The decode and the eight
// ROM byte reads sit between the input register and the output register, and the state
// updates in the same cycle.
// Reset (rst_n low at a clock edge): both stages empty, no address pending, address 0,
// stall, toggle and enable flags clear, no descriptor continuation.
// Stall: while out_tready is low a held result stays on out_tdata; the input register
// still fills once, after which in_tready drops until the output drains.
module usb_ep0_request_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] request_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_length
  input  logic [47:0] in_tdata,
  // [2:0] op
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] byte_count, [67:4] packet_bytes, [75:68] device_address, [76] in_stall,
  // [77] out_stall, [78] in_toggle, [79] out_toggle, [80] function_enabled, [87:81] zero
  output logic [87:0] out_tdata,
  // [2:0] action
  output logic [2:0]  out_tuser
);
  import ue0_pkg::*;

  logic        in_valid_r;
  logic [2:0]  in_op_r;
  logic [47:0] in_data_r;
  state_t      st_r;
  state_t      st_nxt;
  reply_t      reply;
  logic        out_valid_r;
  logic [2:0]  out_action_r;
  logic [87:0] out_data_r;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  ue0_decode u_decode (
    .op             (in_op_r),
    .request_type   (in_data_r[7:0]),
    .request_code   (in_data_r[15:8]),
    .request_value  (in_data_r[31:16]),
    .request_length (in_data_r[47:32]),
    .st_cur         (st_r),
    .st_nxt         (st_nxt),
    .reply          (reply)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.staged_addr <= ADDR_NONE;
      st_r.cur_addr    <= 8'd0;
      st_r.desc_off    <= 6'd0;
      st_r.remaining   <= 5'd0;
      st_r.stall       <= 2'b00;
      st_r.toggle      <= 2'b00;
      st_r.enable      <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action_r <= reply.action;
      out_data_r   <= {7'd0, st_nxt.enable, st_nxt.toggle[1], st_nxt.toggle[0],
                       st_nxt.stall[1], st_nxt.stall[0], st_nxt.cur_addr,
                       reply.bytes, reply.count};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_action_r;

endmodule

FILE: test/tb_usb_ep0_request_responder.sv
// Self-checking testbench for the endpoint-0 standard request responder.
// Drives endpoint events on the in_ stream, predicts every reply and checks the out_ stream.
// Depends on ue0_pkg and usb_ep0_request_responder.
`timescale 1ns / 100ps

module tb_usb_ep0_request_responder;
  import ue0_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_EVENTS = 950;

  // bmRequestType values used by the directed tests.
  localparam logic [7:0] RT_STD_IN   = 8'h80;
  localparam logic [7:0] RT_STD_OUT  = 8'h00;
  localparam logic [7:0] RT_IFACE_IN = 8'h81;
  localparam logic [7:0] RT_ODD_STD  = 8'h9F;
  localparam logic [7:0] RT_VENDOR   = 8'h40;
  localparam logic [7:0] RT_RESERVED = 8'h60;

  // Descriptor layout as the host should see it.
  localparam int DEV_AT    = 0;
  localparam int CFG_AT    = 18;
  localparam int LANG_AT   = 36;
  localparam int MFR_AT    = 40;
  localparam int PROD_AT   = 58;
  localparam int FULL_LEN  = 18;
  localparam int LANG_LEN  = 4;
  localparam int CHUNK_MAX = 8;

  localparam logic [7:0] std_descriptors [ROM_SIZE] = '{
    8'd18, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'd8,
    8'hBA, 8'h0D, 8'h00, 8'h10, 8'hAD, 8'hDE, 8'd1, 8'd2, 8'd0, 8'd1,
    8'd9, 8'h02, 8'd18, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'hFA,
    8'd9, 8'h04, 8'd0, 8'd0, 8'd0, 8'hFF, 8'h00, 8'h00, 8'd0,
    8'd4, 8'h03, 8'h09, 8'h04,
    8'd18, 8'h03, 8'h44, 8'd0, 8'h69, 8'd0, 8'h67, 8'd0, 8'h69, 8'd0,
    8'h53, 8'd0, 8'h61, 8'd0, 8'h66, 8'd0, 8'h65, 8'd0,
    8'd18, 8'h03, 8'h4D, 8'd0, 8'h42, 8'd0, 8'h4F, 8'd0, 8'h58, 8'd0,
    8'h2D, 8'd0, 8'h53, 8'd0, 8'h41, 8'd0, 8'h46, 8'd0
  };

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  count;
    logic [63:0] bytes;
    logic [7:0]  addr;
    logic        in_stall;
    logic        out_stall;
    logic        in_toggle;
    logic        out_toggle;
    logic        enabled;
  } ep0_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [2:0]  out_tuser;

  // Endpoint state as the predictor sees it.
  logic [7:0] m_pending = ADDR_NONE;
  logic [7:0] m_addr = '0;
  logic [5:0] m_offset = '0;
  logic [4:0] m_left = '0;
  logic [1:0] m_stall = '0;
  logic [1:0] m_toggle = '0;
  logic       m_enabled = 1'b0;

  ep0_reply_t replies_due [$];
  int fail_count = 0;
  int counted = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int n_checked = 0;
  int n_packets = 0;
  int n_stalls = 0;
  int n_done = 0;
  logic [9:0] rx_phase = '0;

  usb_ep0_request_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the reply to one event and moves the endpoint state on.
  function automatic ep0_reply_t predict_event(input logic [2:0] op, input logic [7:0] rtype,
                                               input logic [7:0] code, input logic [15:0] value,
                                               input logic [15:0] want);
    ep0_reply_t r;
    logic chunk;
    logic known;
    int unsigned from, avail, n, base, len, i;
    r = '0;
    chunk = 1'b0;
    from = 0;
    avail = 0;
    base = 0;
    len = 0;
    case (op)
      OP_SETUP: begin
        m_stall = 2'b00;
        m_toggle = 2'b11;
        if (rtype == RT_DFU && code == REQ_DFU && value == VAL_DFU) begin
          r.action = ACT_DFU;
        end else begin
          known = ((rtype & RT_TYPE_MASK) == 8'h00);
          if (known) begin
            case (code)
              REQ_GET_STATUS: begin
                r.action = ACT_DATA;
                r.count = 4'd2;
                m_left = '0;
              end
              REQ_SET_ADDRESS: begin
                m_pending = value[7:0];
                r.action = ACT_ZLP;
              end
              REQ_GET_DESCRIPTOR: begin
                if (value[15:8] == DESC_DEVICE) begin
                  base = DEV_AT;
                  len = FULL_LEN;
                end else if (value[15:8] == DESC_CONFIG) begin
                  base = CFG_AT;
                  len = FULL_LEN;
                end else if (value[15:8] == DESC_STRING && value[7:0] == STR_LANG) begin
                  base = LANG_AT;
                  len = LANG_LEN;
                end else if (value[15:8] == DESC_STRING && value[7:0] == STR_MFR) begin
                  base = MFR_AT;
                  len = FULL_LEN;
                end else if (value[15:8] == DESC_STRING && value[7:0] == STR_PRODUCT) begin
                  base = PROD_AT;
                  len = FULL_LEN;
                end else begin
                  known = 1'b0;
                end
                if (known) begin
                  avail = (want < len) ? want : len;
                  if (avail == 0) begin
                    r.action = ACT_ZLP;
                    m_offset = 6'(base >> 1);
                    m_left = '0;
                  end else begin
                    chunk = 1'b1;
                    from = base;
                  end
                end
              end
              REQ_GET_CONFIG: begin
                r.action = ACT_DATA;
                r.count = 4'd1;
                r.bytes = 64'd1;
                m_left = '0;
              end
              REQ_GET_INTERFACE: begin
                r.action = ACT_DATA;
                r.count = 4'd1;
                m_left = '0;
              end
              REQ_SET_CONFIG, REQ_SET_INTERFACE: begin
                r.action = ACT_ZLP;
              end
              default: begin
                known = 1'b0;
              end
            endcase
          end
          if (!known) begin
            m_stall = 2'b11;
            r.action = ACT_STALL;
          end
        end
      end
      OP_IN_DONE: begin
        if (m_pending != ADDR_NONE) begin
          m_addr = m_pending;
          m_pending = ADDR_NONE;
        end
        if (m_left != 0) begin
          chunk = 1'b1;
          from = 2 * m_offset;
          avail = m_left;
        end else begin
          m_stall = 2'b00;
          m_toggle = 2'b00;
          r.action = ACT_DONE;
        end
      end
      OP_BUS_RESET: begin
        m_stall = 2'b00;
        m_toggle = 2'b00;
        m_addr = '0;
        m_enabled = 1'b1;
        m_pending = ADDR_NONE;
        m_left = '0;
      end
      default: begin
      end
    endcase
    if (chunk) begin
      n = (avail > CHUNK_MAX) ? CHUNK_MAX : avail;
      r.action = ACT_DATA;
      r.count = 4'(n);
      for (i = 0; i < n; i++) begin
        if (from + i < ROM_SIZE) begin
          r.bytes[8*i +: 8] = std_descriptors[from + i];
        end
      end
      m_offset = 6'((from + n) >> 1);
      m_left = 5'(avail - n);
    end
    r.addr = m_addr;
    r.in_stall = m_stall[0];
    r.out_stall = m_stall[1];
    r.in_toggle = m_toggle[0];
    r.out_toggle = m_toggle[1];
    r.enabled = m_enabled;
    return r;
  endfunction

  // Offers one event, sometimes idling first when a burst has run out, and records its reply.
  task automatic send_event(input logic [2:0] op, input logic [7:0] rtype, input logic [7:0] code,
                            input logic [15:0] value, input logic [15:0] want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {want, value, code, rtype};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replies_due.push_back(predict_event(op, rtype, code, value, want));
    counted++;
  endtask

  task automatic send_setup(input logic [7:0] rtype, input logic [7:0] code,
                            input logic [15:0] value, input logic [15:0] want);
    send_event(OP_SETUP, rtype, code, value, want);
  endtask

  task automatic send_in_done();
    send_event(OP_IN_DONE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Every reply taken from the out_ stream is held against the oldest prediction.
  always @(posedge clk) begin
    ep0_reply_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with no event outstanding: action %0d", out_tuser);
        fail_count++;
      end else begin
        exp_r = replies_due.pop_front();
        n_checked++;
        if (exp_r.action == ACT_DATA) n_packets++;
        if (exp_r.action == ACT_STALL) n_stalls++;
        if (exp_r.action == ACT_DONE) n_done++;
        check_field("action", exp_r.action, out_tuser);
        check_field("byte_count", exp_r.count, out_tdata[3:0]);
        check_field("packet_bytes", exp_r.bytes, out_tdata[67:4]);
        check_field("device_address", exp_r.addr, out_tdata[75:68]);
        check_field("in_stall", exp_r.in_stall, out_tdata[76]);
        check_field("out_stall", exp_r.out_stall, out_tdata[77]);
        check_field("in_toggle", exp_r.in_toggle, out_tdata[78]);
        check_field("out_toggle", exp_r.out_toggle, out_tdata[79]);
        check_field("function_enabled", exp_r.enabled, out_tdata[80]);
        check_field("padding", '0, out_tdata[87:81]);
      end
    end
  end

  // The receiver cycles through always ready, random, ready one in four and one in eight stalls.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 1);
      2'd2: out_tready <= (rx_phase[1:0] == 2'b00);
      default: out_tready <= (rx_phase[2:0] != 3'd5);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_plain_events();
    send_event(OP_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_event(OP_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_event(OP_OTHER, 8'hA5, 8'h5A, 16'h1234, 16'h5678);
    send_event(3'b111, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    // Nothing left to send, so this completes the transfer.
    send_in_done();
  endtask

  task automatic test_short_replies();
    send_setup(RT_STD_IN, REQ_GET_STATUS, 16'h0000, 16'h0002);
    send_setup(RT_STD_IN, REQ_GET_CONFIG, 16'h0000, 16'h0001);
    send_setup(RT_IFACE_IN, REQ_GET_INTERFACE, 16'hFFFF, 16'hFFFF);
    send_setup(RT_STD_OUT, REQ_SET_CONFIG, 16'h0001, 16'h0000);
    send_setup(RT_ODD_STD, REQ_SET_INTERFACE, 16'h0000, 16'h0000);
  endtask

  task automatic test_set_address();
    send_setup(RT_STD_OUT, REQ_SET_ADDRESS, 16'h007F, 16'h0000);
    send_in_done();
    // An address of all ones means nothing pending, so the old address stays.
    send_setup(RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000);
    send_in_done();
  endtask

  task automatic test_descriptors();
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF);
    send_in_done();
    send_in_done();
    send_in_done();
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'd9);
    send_in_done();
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, STR_LANG}, 16'hFFFF);
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, STR_MFR}, 16'h0000);
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, STR_PRODUCT}, 16'd3);
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd3}, 16'hFFFF);
    send_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, {8'd4, 8'h00}, 16'hFFFF);
  endtask

  task automatic test_vendor_requests();
    send_setup(RT_DFU, REQ_DFU, VAL_DFU, 16'h0000);
    send_setup(RT_DFU, REQ_DFU, VAL_DFU + 16'd1, 16'h0000);
    send_setup(RT_VENDOR, REQ_GET_STATUS, 16'h0000, 16'h0002);
    send_setup(RT_RESERVED, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF);
  endtask

  // Mostly complete control transfers with random content, some cut short, plus noise.
  task automatic test_random_transfers(input int target);
    int kind;
    logic [7:0] rt, cd, lo, hi;
    logic [15:0] len;
    while (counted < target) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_event(OP_BUS_RESET, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else if (kind < 3) begin
        send_event(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        rt = {1'($urandom), 2'b00, 5'($urandom)};
        lo = 8'($urandom);
        hi = 8'($urandom);
        len = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          cd = REQ_GET_DESCRIPTOR;
          case ($urandom_range(0, 7))
            0, 1: hi = DESC_DEVICE;
            2, 3: hi = DESC_CONFIG;
            4, 5, 6: begin
              hi = DESC_STRING;
              if ($urandom_range(0, 7) != 0) lo = 8'($urandom_range(0, 3));
            end
            default: begin
            end
          endcase
        end else if (kind == 5) begin
          cd = REQ_SET_ADDRESS;
          if ($urandom_range(0, 7) == 0) lo = ADDR_NONE;
        end else if (kind == 6) begin
          case ($urandom_range(0, 4))
            0: cd = REQ_GET_STATUS;
            1: cd = REQ_GET_CONFIG;
            2: cd = REQ_GET_INTERFACE;
            3: cd = REQ_SET_CONFIG;
            default: cd = REQ_SET_INTERFACE;
          endcase
        end else if (kind == 7) begin
          rt = RT_DFU;
          cd = REQ_DFU;
          {hi, lo} = VAL_DFU;
        end else begin
          rt = 8'($urandom);
          cd = 8'($urandom);
        end
        send_setup(rt, cd, {hi, lo}, len);
        while (m_left != 0 && $urandom_range(0, 15) != 0) begin
          if ($urandom_range(0, 7) == 0) begin
            send_event(OP_OUT_DONE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
          end else begin
            send_in_done();
          end
        end
        if ($urandom_range(0, 3) != 0) send_in_done();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_events();
    test_short_replies();
    test_set_address();
    test_descriptors();
    test_vendor_requests();
    test_random_transfers(counted + RANDOM_EVENTS);
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d replies: %0d data packets, %0d stalls, %0d completed transfers.",
             n_checked, n_packets, n_stalls, n_done);
    $display("Events covered every request kind, descriptor chunking, address changes and resets.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ue0_pkg.sv
src/ue0_decode.sv
src/usb_ep0_request_responder.sv
test/tb_usb_ep0_request_responder.sv
